>>> rtl/core/priority_tsp_held_karp_unit_macros.svh
// ----------------------------------------------------------------------------
// priority tsp held-karp unit assertion macros
// shared assertion forms, clocked on clk with rst_n low as the disable
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TSP_HELD_KARP_UNIT_MACROS_SVH
`define PRIORITY_TSP_HELD_KARP_UNIT_MACROS_SVH

// same-cycle implication
`define PTHK_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pthk: same-cycle check failed");

// next-cycle implication
`define PTHK_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pthk: next-cycle check failed");

`endif

>>> rtl/core/pthk_pkg.sv
// ----------------------------------------------------------------------------
// pthk_pkg
// types, sizes and helpers of the priority tsp held-karp unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pthk_pkg;

    localparam int MAX_NODES  = 12;
    localparam int DIST_BITS  = 24;
    localparam int NODE_W     = 4;
    localparam int DIN_W      = 24;
    localparam int COST_W     = 28;
    localparam int DIST_W     = (DIST_BITS < DIN_W) ? DIST_BITS : DIN_W;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int SUBSET_W   = MAX_NODES;
    localparam int CNT_W      = $clog2(MAX_NODES + 2);
    localparam int NCNT_W     = 4;
    localparam int DIST_DEPTH = MAX_NODES * MAX_NODES;
    localparam int DADDR_W    = $clog2(DIST_DEPTH);
    localparam int COST_DEPTH = (1 << MAX_NODES) * MAX_NODES;
    localparam int CADDR_W    = $clog2(COST_DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_INDEX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MASK = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [DIN_W-1:0]  distance;
        logic              last_entry;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] tour_node;
        logic [NODE_W-1:0] tour_position;
        logic [COST_W-1:0] total_cost;
        logic              last_result;
    } result_t;

    typedef struct packed {
        logic              reached;
        logic [IDX_W-1:0]  parent;
        logic [COST_W-1:0] cost;
    } cost_entry_t;

    localparam int CENTRY_W = $bits(cost_entry_t);

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + (COST_W + 1)'(b);
        return s[COST_W] ? COST_SAT : s[COST_W-1:0];
    endfunction

    function automatic logic [CADDR_W-1:0] cost_addr(input logic [SUBSET_W-1:0] m,
                                                     input logic [IDX_W-1:0] node);
        return CADDR_W'(m) * CADDR_W'(MAX_NODES) + CADDR_W'(node);
    endfunction

    function automatic logic [DADDR_W-1:0] dist_addr(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        return DADDR_W'(r) * DADDR_W'(MAX_NODES) + DADDR_W'(c);
    endfunction

endpackage

>>> rtl/core/pthk_ram.sv
// ----------------------------------------------------------------------------
// pthk_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pthk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/priority_tsp_held_karp_unit.sv
// operation: each in-range beat loads one matrix entry; a beat with last_entry then starts a
// solve that clears all COST_DEPTH (49152) cost entries, visits every subset/last-node pair,
// reads the cost of pairs whose node is in the subset, relaxes each open transition of a reached
// pair, scans every closing candidate but the depot, backtracks the stops and emits result beats
// throughput: one item at a time; the cost memory takes one read and one write per cycle
// reset: rst_n low clears all control state, node_count 12, depot 0, priority mask 0
// ----------------------------------------------------------------------------
// priority_tsp_held_karp_unit
// held-karp tour solver with priority stops over a loaded distance matrix
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_tsp_held_karp_unit_macros.svh"

module priority_tsp_held_karp_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  pthk_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output pthk_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pthk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pthk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pthk_pkg::*;

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLR    = 4'd1;
    localparam logic [3:0] ST_INIT   = 4'd2;
    localparam logic [3:0] ST_ML_RD  = 4'd3;
    localparam logic [3:0] ST_ML_CHK = 4'd4;
    localparam logic [3:0] ST_NX     = 4'd5;
    localparam logic [3:0] ST_NX_UPD = 4'd6;
    localparam logic [3:0] ST_CL_RD  = 4'd7;
    localparam logic [3:0] ST_CL_UPD = 4'd8;
    localparam logic [3:0] ST_BT_INI = 4'd9;
    localparam logic [3:0] ST_BT_RD  = 4'd10;
    localparam logic [3:0] ST_BT_UPD = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    // configuration registers
    logic [NCNT_W-1:0]   node_count_reg;
    logic [NODE_W-1:0]   depot_reg;
    logic [SUBSET_W-1:0] pmask_reg;

    // sequencer and solve state
    logic [3:0]          state_reg, state_next;
    logic [IDX_W-1:0]    n_m1_reg, n_m1_next;
    logic [IDX_W-1:0]    dep_reg, dep_next;
    logic [SUBSET_W-1:0] full_reg, full_next;
    logic [SUBSET_W-1:0] hp_reg, hp_next;
    logic [SUBSET_W-1:0] m_reg, m_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [IDX_W-1:0]    nx_reg, nx_next;
    logic [COST_W-1:0]   c_reg, c_next;
    logic [CADDR_W-1:0]  clr_reg, clr_next;
    logic [COST_W-1:0]   best_reg, best_next;
    logic                best_ok_reg, best_ok_next;
    logic [IDX_W-1:0]    best_last_reg, best_last_next;
    logic [SUBSET_W-1:0] bt_mask_reg, bt_mask_next;
    logic [IDX_W-1:0]    bt_cur_reg, bt_cur_next;
    logic                bt_ok_reg, bt_ok_next;
    logic [CNT_W-1:0]    bt_cnt_reg, bt_cnt_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    path_reg [MAX_NODES];
    logic                path_we;
    result_t             result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    // memory ports
    logic                dist_we;
    logic [DADDR_W-1:0]  dist_waddr;
    logic [DADDR_W-1:0]  dist_raddr;
    logic [DIST_W-1:0]   dist_rdata;
    logic                cost_we;
    logic [CADDR_W-1:0]  cost_waddr;
    logic [CADDR_W-1:0]  cost_raddr;
    cost_entry_t         cost_wdata;
    cost_entry_t         cost_rdata;

    // normalized problem at solve start
    logic [NCNT_W-1:0]   n_norm;
    logic [SUBSET_W-1:0] full_norm;
    logic [IDX_W-1:0]    dep_norm;

    // per-step helpers
    logic                item_acc;
    logic                all_hp;
    logic [SUBSET_W-1:0] nm;
    logic                nx_skip;
    logic [COST_W-1:0]   sum_cost;
    logic                adv;
    logic                bt_stop;
    logic [IDX_W-1:0]    path_idx;

    assign item_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign item_acc     = item_valid && item_ready;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_norm = NCNT_W'(1);
        end
        else if (node_count_reg > NCNT_W'(MAX_NODES))
        begin
            n_norm = NCNT_W'(MAX_NODES);
        end
        else
        begin
            n_norm = node_count_reg;
        end
        full_norm = ~({SUBSET_W{1'b1}} << n_norm);
        dep_norm  = (NCNT_W'(depot_reg) < n_norm) ? IDX_W'(depot_reg) : '0;
    end

    // distance matrix writes; out-of-range entries are dropped
    assign dist_we    = item_acc && (item.from_node < NODE_W'(MAX_NODES))
                        && (item.to_node < NODE_W'(MAX_NODES));
    assign dist_waddr = dist_addr(IDX_W'(item.from_node), IDX_W'(item.to_node));

    pthk_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DIST_DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (item.distance[DIST_W-1:0]),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // cost, parent and reached flag of each subset/last-node pair
    pthk_ram #(
        .WIDTH (CENTRY_W),
        .DEPTH (COST_DEPTH)
    ) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    assign all_hp   = ((m_reg & hp_reg) == hp_reg);
    assign nm       = m_reg | (SUBSET_W'(1) << nx_reg);
    assign nx_skip  = m_reg[nx_reg] || (nx_reg == dep_reg) || (!all_hp && !hp_reg[nx_reg]);
    assign sum_cost = sat_add((state_reg == ST_NX_UPD) ? c_reg : cost_rdata.cost, dist_rdata);
    assign bt_stop  = !bt_ok_reg || (bt_cur_reg == dep_reg) || (bt_cnt_reg > CNT_W'(n_m1_reg))
                      || (bt_cur_reg > n_m1_reg);
    assign path_idx = IDX_W'(bt_cnt_reg - k_reg);

    always_comb
    begin
        state_next        = state_reg;
        n_m1_next         = n_m1_reg;
        dep_next          = dep_reg;
        full_next         = full_reg;
        hp_next           = hp_reg;
        m_next            = m_reg;
        last_next         = last_reg;
        nx_next           = nx_reg;
        c_next            = c_reg;
        clr_next          = clr_reg;
        best_next         = best_reg;
        best_ok_next      = best_ok_reg;
        best_last_next    = best_last_reg;
        bt_mask_next      = bt_mask_reg;
        bt_cur_next       = bt_cur_reg;
        bt_ok_next        = bt_ok_reg;
        bt_cnt_next       = bt_cnt_reg;
        k_next            = k_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        path_we           = 1'b0;
        adv               = 1'b0;
        cost_we           = 1'b0;
        cost_waddr        = clr_reg;
        cost_wdata        = '0;
        cost_raddr        = cost_addr(m_reg, last_reg);
        dist_raddr        = dist_addr(last_reg, nx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && item.last_entry)
                begin
                    n_m1_next = IDX_W'(n_norm - NCNT_W'(1));
                    dep_next  = dep_norm;
                    full_next = full_norm;
                    hp_next   = pmask_reg & full_norm & ~(SUBSET_W'(1) << dep_norm);
                    clr_next  = '0;
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                // sweep the whole cost memory back to unreached
                cost_we = 1'b1;
                if (clr_reg == CADDR_W'(COST_DEPTH - 1))
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    clr_next = clr_reg + CADDR_W'(1);
                end
            end
            ST_INIT:
            begin
                cost_we    = 1'b1;
                cost_waddr = cost_addr(SUBSET_W'(1) << dep_reg, dep_reg);
                cost_wdata = '{reached: 1'b1, parent: dep_reg, cost: '0};
                m_next     = SUBSET_W'(1);
                last_next  = '0;
                state_next = ST_ML_RD;
            end
            ST_ML_RD:
            begin
                if (!m_reg[last_reg])
                begin
                    adv = 1'b1;
                end
                else
                begin
                    state_next = ST_ML_CHK;
                end
            end
            ST_ML_CHK:
            begin
                if (cost_rdata.reached)
                begin
                    c_next     = cost_rdata.cost;
                    nx_next    = '0;
                    state_next = ST_NX;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_NX:
            begin
                cost_raddr = cost_addr(nm, nx_reg);
                if (nx_skip)
                begin
                    if (nx_reg == n_m1_reg)
                    begin
                        adv = 1'b1;
                    end
                    else
                    begin
                        nx_next = nx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_NX_UPD;
                end
            end
            ST_NX_UPD:
            begin
                // relax one transition; strict compare keeps the earlier parent
                if (!cost_rdata.reached || (sum_cost < cost_rdata.cost))
                begin
                    cost_we    = 1'b1;
                    cost_waddr = cost_addr(nm, nx_reg);
                    cost_wdata = '{reached: 1'b1, parent: last_reg, cost: sum_cost};
                end
                if (nx_reg == n_m1_reg)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    nx_next    = nx_reg + IDX_W'(1);
                    state_next = ST_NX;
                end
            end
            ST_CL_RD:
            begin
                cost_raddr = cost_addr(full_reg, nx_reg);
                dist_raddr = dist_addr(nx_reg, dep_reg);
                if (nx_reg == dep_reg)
                begin
                    if (nx_reg == n_m1_reg)
                    begin
                        state_next = ST_BT_INI;
                    end
                    else
                    begin
                        nx_next = nx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_CL_UPD;
                end
            end
            ST_CL_UPD:
            begin
                if (cost_rdata.reached && (!best_ok_reg || (sum_cost < best_reg)))
                begin
                    best_next      = sum_cost;
                    best_ok_next   = 1'b1;
                    best_last_next = nx_reg;
                end
                if (nx_reg == n_m1_reg)
                begin
                    state_next = ST_BT_INI;
                end
                else
                begin
                    nx_next    = nx_reg + IDX_W'(1);
                    state_next = ST_CL_RD;
                end
            end
            ST_BT_INI:
            begin
                if (!best_ok_reg)
                begin
                    best_next = '0;
                end
                bt_mask_next = full_reg;
                bt_cur_next  = best_last_reg;
                bt_ok_next   = best_ok_reg;
                bt_cnt_next  = '0;
                state_next   = ST_BT_RD;
            end
            ST_BT_RD:
            begin
                cost_raddr = cost_addr(bt_mask_reg, bt_cur_reg);
                if (bt_stop)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    path_we    = 1'b1;
                    state_next = ST_BT_UPD;
                end
            end
            ST_BT_UPD:
            begin
                bt_cur_next  = cost_rdata.parent;
                bt_mask_next = bt_mask_reg ^ (SUBSET_W'(1) << bt_cur_reg);
                bt_cnt_next  = bt_cnt_reg + CNT_W'(1);
                state_next   = ST_BT_RD;
            end
            ST_EMIT:
            begin
                // depot, stops in forward order, depot
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next         = 1'b1;
                    result_next.tour_position = NODE_W'(k_reg);
                    result_next.total_cost    = best_reg;
                    result_next.last_result   = (k_reg == bt_cnt_reg + CNT_W'(1));
                    if ((k_reg == '0) || (k_reg == bt_cnt_reg + CNT_W'(1)))
                    begin
                        result_next.tour_node = NODE_W'(dep_reg);
                    end
                    else
                    begin
                        result_next.tour_node = NODE_W'(path_reg[path_idx]);
                    end
                    if (k_reg == bt_cnt_reg + CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next subset/last-node pair
        if (adv)
        begin
            state_next = ST_ML_RD;
            if (last_reg == n_m1_reg)
            begin
                if (m_reg == full_reg)
                begin
                    nx_next      = '0;
                    best_ok_next = 1'b0;
                    best_next    = '0;
                    best_last_next = '0;
                    state_next   = ST_CL_RD;
                end
                else
                begin
                    m_next    = m_reg + SUBSET_W'(1);
                    last_next = '0;
                end
            end
            else
            begin
                last_next = last_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= NCNT_W'(MAX_NODES);
            depot_reg        <= '0;
            pmask_reg        <= '0;
            state_reg        <= ST_IDLE;
            n_m1_reg         <= '0;
            dep_reg          <= '0;
            full_reg         <= '0;
            hp_reg           <= '0;
            m_reg            <= '0;
            last_reg         <= '0;
            nx_reg           <= '0;
            c_reg            <= '0;
            clr_reg          <= '0;
            best_reg         <= '0;
            best_ok_reg      <= 1'b0;
            best_last_reg    <= '0;
            bt_mask_reg      <= '0;
            bt_cur_reg       <= '0;
            bt_ok_reg        <= 1'b0;
            bt_cnt_reg       <= '0;
            k_reg            <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT:    node_count_reg <= NCNT_W'(cfg_data[NODE_W-1:0]);
                    CFG_DEPOT_INDEX:   depot_reg      <= cfg_data[NODE_W-1:0];
                    CFG_PRIORITY_MASK: pmask_reg      <= SUBSET_W'(cfg_data);
                    default:           ;
                endcase
            end
            state_reg        <= state_next;
            n_m1_reg         <= n_m1_next;
            dep_reg          <= dep_next;
            full_reg         <= full_next;
            hp_reg           <= hp_next;
            m_reg            <= m_next;
            last_reg         <= last_next;
            nx_reg           <= nx_next;
            c_reg            <= c_next;
            clr_reg          <= clr_next;
            best_reg         <= best_next;
            best_ok_reg      <= best_ok_next;
            best_last_reg    <= best_last_next;
            bt_mask_reg      <= bt_mask_next;
            bt_cur_reg       <= bt_cur_next;
            bt_ok_reg        <= bt_ok_next;
            bt_cnt_reg       <= bt_cnt_next;
            k_reg            <= k_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // backtracked stops, newest first
    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_reg[IDX_W'(bt_cnt_reg)] <= bt_cur_reg;
        end
    end

    `PTHK_ASSERT_NXT(a_solve_starts, item_acc && item.last_entry, state_reg == ST_CLR)
    `PTHK_ASSERT_IMP(a_legal_step, state_reg == ST_NX_UPD,
                     !m_reg[nx_reg] && (nx_reg != dep_reg))
    `PTHK_ASSERT_IMP(a_path_bound, state_reg == ST_EMIT, bt_cnt_reg <= CNT_W'(MAX_NODES))

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// priority tsp held-karp unit testbench
// loads distance matrices, solves tours under several node counts, depots and
// priority masks, and checks every tour beat against a held-karp predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import pthk_pkg::*;

    localparam int unsigned UNREACHED = 32'hFFFF_FFFF;
    localparam int unsigned SAT_COST  = 32'h0FFF_FFFF;
    localparam int unsigned NO_PARENT = 255;
    localparam int          STALL_LIMIT = 2_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    priority_tsp_held_karp_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state: registers, distance matrix and solve tables
    logic [3:0]  node_reg;
    logic [3:0]  depot_reg;
    logic [11:0] prio_reg;
    logic [23:0] dist_mem [MAX_NODES][MAX_NODES];
    bit          dist_seen [MAX_NODES][MAX_NODES];
    int unsigned path_cost [(1 << MAX_NODES) * MAX_NODES];
    int unsigned path_prev [(1 << MAX_NODES) * MAX_NODES];

    result_t tour_expect[$];
    int      mismatches;
    bit      calm;        // no idling on either side while set
    int      hold_left;   // receiver hold-off cycles still to go

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned add_sat(input int unsigned a, input int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > SAT_COST) ? SAT_COST : int'(s);
    endfunction

    // held-karp over the configured nodes, queues the tour beats
    function automatic void predict_tour();
        int unsigned n, dep, full, hp, m, lst, nx, nm, c, nc, best, best_last;
        int unsigned cur, cnt, k, node, mask;
        bit          all_hp;
        int unsigned path [MAX_NODES];
        result_t     r;
        n = (node_reg == 0) ? 1 : ((node_reg > MAX_NODES) ? MAX_NODES : node_reg);
        dep = (depot_reg < n) ? depot_reg : 0;
        full = (1 << n) - 1;
        hp = prio_reg & full & ~(1 << dep);
        foreach (path_cost[i]) begin
            path_cost[i] = UNREACHED;
            path_prev[i] = NO_PARENT;
        end
        path_cost[(1 << dep) * MAX_NODES + dep] = 0;
        for (m = 1; m <= full; m++) begin
            all_hp = ((m & hp) == hp);
            for (lst = 0; lst < n; lst++) begin
                if (!m[lst]) continue;
                c = path_cost[m * MAX_NODES + lst];
                if (c == UNREACHED) continue;
                for (nx = 0; nx < n; nx++) begin
                    if (m[nx] || nx == dep) continue;
                    if (!all_hp && !hp[nx]) continue;
                    nm = m | (1 << nx);
                    nc = add_sat(c, dist_mem[lst][nx]);
                    if (nc < path_cost[nm * MAX_NODES + nx]) begin
                        path_cost[nm * MAX_NODES + nx] = nc;
                        path_prev[nm * MAX_NODES + nx] = lst;
                    end
                end
            end
        end
        best = UNREACHED;
        best_last = NO_PARENT;
        for (k = 0; k < n; k++) begin
            if (k == dep) continue;
            c = path_cost[full * MAX_NODES + k];
            if (c == UNREACHED) continue;
            nc = add_sat(c, dist_mem[k][dep]);
            if (nc < best) begin
                best = nc;
                best_last = k;
            end
        end
        if (best == UNREACHED) best = 0;
        // walk parents back from the closing stop
        cnt = 0;
        mask = full;
        cur = best_last;
        while (cur != NO_PARENT && cur != dep && cnt < n && cur < n) begin
            path[cnt++] = cur;
            k = path_prev[mask * MAX_NODES + cur];
            mask ^= (1 << cur);
            cur = k;
        end
        for (k = 0; k <= cnt + 1; k++) begin
            node = (k == 0 || k == cnt + 1) ? dep : path[cnt - k];
            r.tour_node = node[3:0];
            r.tour_position = k[3:0];
            r.total_cost = best[27:0];
            r.last_result = (k == cnt + 1);
            tour_expect = {tour_expect, r};
        end
    endfunction

    // result side: random ready, hold-off stretches, beat checking
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (tour_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected tour beat: node %0d pos %0d cost %0d last %0b",
                                 result.tour_node, result.tour_position,
                                 result.total_cost, result.last_result);
                end
                else begin
                    if (result !== tour_expect[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tour beat mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     tour_expect[0].tour_node, tour_expect[0].tour_position,
                                     tour_expect[0].total_cost, tour_expect[0].last_result,
                                     result.tour_node, result.tour_position,
                                     result.total_cost, result.last_result);
                    end
                    void'(tour_expect.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else begin
                result_ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    // watchdog: cycles with no beat on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // entered and left at a rising edge; valid stays up between back-to-back beats
    task automatic send_entry(input logic [3:0] from_n, input logic [3:0] to_n,
                              input logic [23:0] dist_val, input bit last);
        int gap;
        item_t x;
        gap = 0;
        while (!calm && $urandom_range(99) < 17) gap++;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        x.from_node = from_n;
        x.to_node = to_n;
        x.distance = dist_val;
        x.last_entry = last;
        item <= x;
        item_valid <= 1'b1;
        @(negedge clk);
        while (!item_ready) @(negedge clk);
        @(posedge clk);
        if (from_n < MAX_NODES && to_n < MAX_NODES) begin
            dist_mem[from_n][to_n] = dist_val;
            dist_seen[from_n][to_n] = 1'b1;
        end
        if (last) predict_tour();
    endtask

    // sender pauses until every tour beat is back, then lets the block settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tour_expect.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_COUNT:    node_reg = val[3:0];
            CFG_DEPOT_INDEX:   depot_reg = val[3:0];
            CFG_PRIORITY_MASK: prio_reg = val[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_problem(input logic [3:0] n, input logic [3:0] dep, input logic [11:0] pm);
        write_reg(CFG_NODE_COUNT, {8'd0, n});
        write_reg(CFG_DEPOT_INDEX, {8'd0, dep});
        write_reg(CFG_PRIORITY_MASK, pm);
    endtask

    // writes every entry of the active square that was never loaded
    task automatic fill_matrix(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!dist_seen[r][c])
                    send_entry(r[3:0], c[3:0], 24'($urandom), 1'b0);
    endtask

    function automatic int active_nodes();
        return (node_reg == 0) ? 1 : ((node_reg > MAX_NODES) ? MAX_NODES : node_reg);
    endfunction

    // zero and single node counts: depot, depot at cost zero
    task automatic test_single_node();
        set_problem(4'd1, 4'd0, 12'h000);
        send_entry(4'd15, 4'd15, 24'hFFFFFF, 1'b1);   // out-of-range write, still solves
        wait_idle();
        set_problem(4'd0, 4'd9, 12'hFFF);             // zero count, depot out of range
        send_entry(4'd12, 4'd3, 24'h000000, 1'b1);
        wait_idle();
    endtask

    // four nodes, extreme distances, equal-cost ties, depot and stray priority bits
    task automatic test_small_directed();
        set_problem(4'd4, 4'd3, 12'hF09);   // depot bit and bits above the count ignored
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_entry(r[3:0], c[3:0], (r == c) ? 24'h0 : 24'd100, 1'b0);
        send_entry(4'd0, 4'd1, 24'd100, 1'b1);       // all ties
        wait_idle();
        send_entry(4'd2, 4'd0, 24'hFFFFFF, 1'b0);
        send_entry(4'd1, 4'd2, 24'h000000, 1'b0);
        send_entry(4'd3, 4'd1, 24'hFFFFFF, 1'b1);
        wait_idle();
        write_reg(CFG_PRIORITY_MASK, 12'h004);
        send_entry(4'd3, 4'd2, 24'hFFFFFF, 1'b1);    // priority stop forced first
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        calm = 1'b0;
        set_problem(4'd3, 4'd1, 12'h001);
        fill_matrix(3);
        hold_left = 60000;
        send_entry(4'd2, 4'd0, 24'($urandom), 1'b1);
        for (int i = 0; i < 2; i++)
            send_entry(4'($urandom_range(2)), 4'($urandom_range(2)), 24'($urandom), i == 1);
        wait_idle();
    endtask

    // largest problem: count above the maximum, top depot, every node priority
    task automatic test_full_size();
        calm = 1'b1;
        set_problem(4'd15, 4'd11, 12'hFFF);
        fill_matrix(MAX_NODES);
        send_entry(4'd11, 4'd0, 24'($urandom), 1'b1);
        wait_idle();
        calm = 1'b0;
    endtask

    // random problems of mostly small size with random rewrites and stray writes
    task automatic test_random();
        int n;
        for (int ph = 0; ph < 2; ph++) begin
            if (ph != 1) begin
                wait_idle();
                set_problem(4'($urandom_range(2, 7)), 4'($urandom_range(15)),
                            12'($urandom));
            end
            n = active_nodes();
            fill_matrix(n);
            for (int i = 0; i < 2; i++) begin
                if ($urandom_range(9) == 0)
                    send_entry(4'($urandom_range(12, 15)), 4'($urandom), 24'($urandom), 1'b0);
                else
                    send_entry(4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)),
                               24'($urandom), 1'b0);
            end
            send_entry(4'($urandom), 4'($urandom_range(n - 1)), 24'($urandom), 1'b1);
        end
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        calm = 1'b0;
        hold_left = 0;
        node_reg = 4'd12;
        depot_reg = 4'd0;
        prio_reg = 12'd0;
        foreach (dist_mem[r, c]) begin
            dist_mem[r][c] = '0;
            dist_seen[r][c] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_node();
        test_small_directed();
        test_backpressure();
        test_full_size();
        test_random();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && tour_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
